// ===== hdl/miex_pkg.sv =====
// Package with opcode constants, result type and helpers for the immediate execute block.
package miex_pkg;

	localparam logic [1:0] ST_EXEC = 2'd0;
	localparam logic [1:0] ST_NOTH = 2'd1;
	localparam logic [1:0] ST_UNKN = 2'd2;

	localparam logic [5:0] OP_SPECIAL = 6'h00;
	localparam logic [5:0] OP_REGIMM  = 6'h01;
	localparam logic [5:0] OP_J       = 6'h02;
	localparam logic [5:0] OP_JAL     = 6'h03;
	localparam logic [5:0] OP_ADDI    = 6'h08;
	localparam logic [5:0] OP_ADDIU   = 6'h09;
	localparam logic [5:0] OP_SLTI    = 6'h0A;
	localparam logic [5:0] OP_SLTIU   = 6'h0B;
	localparam logic [5:0] OP_ANDI    = 6'h0C;
	localparam logic [5:0] OP_ORI     = 6'h0D;
	localparam logic [5:0] OP_XORI    = 6'h0E;
	localparam logic [5:0] OP_LUI     = 6'h0F;
	localparam logic [5:0] OP_DADDIU  = 6'h19;
	localparam logic [5:0] OP_LDL     = 6'h1A;
	localparam logic [5:0] OP_LDR     = 6'h1B;
	localparam logic [5:0] OP_LB      = 6'h20;
	localparam logic [5:0] OP_LH      = 6'h21;
	localparam logic [5:0] OP_LWL     = 6'h22;
	localparam logic [5:0] OP_LW      = 6'h23;
	localparam logic [5:0] OP_LBU     = 6'h24;
	localparam logic [5:0] OP_LHU     = 6'h25;
	localparam logic [5:0] OP_LWR     = 6'h26;
	localparam logic [5:0] OP_LWU     = 6'h27;
	localparam logic [5:0] OP_SB      = 6'h28;
	localparam logic [5:0] OP_SH      = 6'h29;
	localparam logic [5:0] OP_SWL     = 6'h2A;
	localparam logic [5:0] OP_SW      = 6'h2B;
	localparam logic [5:0] OP_SDL     = 6'h2C;
	localparam logic [5:0] OP_SDR     = 6'h2D;
	localparam logic [5:0] OP_SWR     = 6'h2E;
	localparam logic [5:0] OP_CACHE   = 6'h2F;
	localparam logic [5:0] OP_PREF    = 6'h33;
	localparam logic [5:0] OP_LD      = 6'h37;
	localparam logic [5:0] OP_SD      = 6'h3F;

	localparam logic [4:0] RI_MTSAB = 5'h18;
	localparam logic [4:0] RI_MTSAH = 5'h19;

	// Decoded instruction handed from the read stage to the execute stage.
	typedef struct packed {
		logic [1:0]  status;
		logic [5:0]  op;
		logic [4:0]  rt;
		logic [15:0] imm;
		logic [31:0] pc;
		logic [25:0] jidx;
	} dec_t;

	typedef struct packed {
		logic [1:0]  status;
		logic        reg_write;
		logic [4:0]  reg_index;
		logic [63:0] reg_value;
		logic        mem_write;
		logic [11:0] mem_word_index;
		logic [63:0] mem_word_value;
		logic [7:0]  mem_byte_mask;
		logic        branch_taken;
		logic [31:0] branch_target;
		logic        nullify_next;
		logic [3:0]  shift_amount_out;
	} res_t;

	function automatic logic [63:0] sx32(input logic [31:0] v);
		return {{32{v[31]}}, v};
	endfunction

	function automatic logic [63:0] lanes(input logic [7:0] m);
		logic [63:0] e;
		for (int i = 0; i < 8; i++) e[8*i +: 8] = {8{m[i]}};
		return e;
	endfunction

	function automatic logic [1:0] classify(input logic [5:0] op, input logic [4:0] rt);
		logic [1:0] s;
		case (op)
			6'h00, 6'h10, 6'h11, 6'h12, 6'h13, 6'h1C, 6'h1E, 6'h1F,
			6'h31, 6'h36, 6'h39, 6'h3E: s = ST_NOTH;
			OP_REGIMM: s = (rt[3:2] == 2'b00 || rt == RI_MTSAB || rt == RI_MTSAH) ?
				ST_EXEC : ST_UNKN;
			6'h02, 6'h03, 6'h04, 6'h05, 6'h06, 6'h07, 6'h14, 6'h15, 6'h16, 6'h17,
			6'h08, 6'h09, 6'h0A, 6'h0B, 6'h0C, 6'h0D, 6'h0E, 6'h0F, 6'h19,
			6'h1A, 6'h1B, 6'h20, 6'h21, 6'h22, 6'h23, 6'h24, 6'h25, 6'h26, 6'h27,
			6'h28, 6'h29, 6'h2A, 6'h2B, 6'h2C, 6'h2D, 6'h2E, 6'h2F, 6'h33,
			6'h37, 6'h3F: s = ST_EXEC;
			default: s = ST_UNKN;
		endcase
		return s;
	endfunction

endpackage

// ===== hdl/mips_immediate_load_store_execute.sv =====
// Top level of the immediate, branch, load and store execute block.
//  channel | dir | tdata fields (low bit up)
//  s_axis  | in  | instr_word[31:0], instr_pc[63:32]
//  m_axis  | out | see m_tdata comment
// An instruction first reads the register file, then computes the address and reads
// the data word, then it executes and writes back. A new instruction is taken only
// while the read stage is empty, so it can enter while the previous one executes.
// Reset clears the registers (through valid bits), the shift amount and the pipeline.
// While a result waits in the output register, the next one is held in the execute
// stage and no new beat is taken until that one can complete.
module mips_immediate_load_store_execute
	import miex_pkg::*;
#(
	parameter int MEM_WORDS = 4096
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [63:0]  s_tdata,
	output logic         m_tvalid,
	input  logic         m_tready,
	// status[1:0], reg_write[2], reg_index[7:3], reg_value[71:8], mem_write[72],
	// mem_word_index[84:73], mem_word_value[148:85], mem_byte_mask[156:149],
	// branch_taken[157], branch_target[189:158], nullify_next[190],
	// shift_amount_out[194:191], zero fill[199:195]
	output logic [199:0] m_tdata
);
	localparam int AW = $clog2(MEM_WORDS);

	dec_t        dec_s1, dec_s2;
	logic        v_s1, v_s2;
	logic [63:0] a, b, a_s2, b_s2, word, wr_word;
	logic [31:0] addr_s2, addr_c;
	logic [3:0]  sa_q, sa_new;
	logic        sa_we;
	res_t        res, res_x, out_q;
	logic        full_q;
	logic [AW-1:0] widx_s2;
	logic        fire, adv2, stall2, done2;

	// The execute stage waits while the output register holds an unaccepted beat.
	assign stall2 = v_s2 && full_q && !m_tready;
	assign done2 = v_s2 && !stall2;

	// One item in stages at a time; an item may enter when the read stage is empty and the execute stage does not stall.
	assign s_tready = !v_s1 && !stall2;
	assign fire = s_tvalid && s_tready;
	assign adv2 = v_s1;

	miex_regfile u_rf (
		.clk(clk), .arst_n(arst_n), .rd_en(fire),
		.rd_a(s_tdata[25:21]), .rd_b(s_tdata[20:16]),
		.a_data(a), .b_data(b),
		.wr_en(done2 && res.reg_write), .wr_idx(res.reg_index), .wr_data(res.reg_value)
	);

	assign addr_c = a[31:0] + {{16{dec_s1.imm[15]}}, dec_s1.imm};

	miex_dmem #(.AW(AW)) u_mem (
		.clk(clk), .rd_en(adv2), .rd_idx(addr_c[AW+2:3]), .rd_data(word),
		.wr_en(done2 && res.mem_write), .wr_idx(widx_s2), .wr_data(wr_word)
	);
	assign wr_word = res.mem_word_value;

	miex_alu u_alu (
		.dec(dec_s2), .a(a_s2), .b(b_s2), .addr(addr_s2), .word(word), .sa_in(sa_q),
		.res(res), .sa_we(sa_we), .sa_new(sa_new)
	);

	always_comb begin
		res_x = res;
		res_x.mem_word_index = res.mem_write ? 12'(widx_s2) : 12'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0; v_s2 <= 1'b0; full_q <= 1'b0; sa_q <= '0;
		end else begin
			v_s1 <= fire;
			v_s2 <= adv2 || stall2;
			if (done2) full_q <= 1'b1;
			else if (m_tready) full_q <= 1'b0;
			if (done2 && sa_we) sa_q <= sa_new;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			dec_s1.status <= (s_tdata[31:0] == 32'd0) ? ST_EXEC :
				classify(s_tdata[31:26], s_tdata[20:16]);
			dec_s1.op   <= (s_tdata[31:0] == 32'd0) ? OP_PREF : s_tdata[31:26];
			dec_s1.rt   <= s_tdata[20:16];
			dec_s1.imm  <= s_tdata[15:0];
			dec_s1.jidx <= s_tdata[25:0];
			dec_s1.pc   <= s_tdata[63:32];
		end
		if (adv2) begin
			dec_s2 <= dec_s1; a_s2 <= a; b_s2 <= b; addr_s2 <= addr_c;
			widx_s2 <= addr_c[AW+2:3];
		end
		if (done2) out_q <= res_x;
	end

	assign m_tvalid = full_q;
	assign m_tdata = {5'd0, out_q.shift_amount_out, out_q.nullify_next,
		out_q.branch_target, out_q.branch_taken, out_q.mem_byte_mask,
		out_q.mem_word_value, out_q.mem_word_index, out_q.mem_write,
		out_q.reg_value, out_q.reg_index, out_q.reg_write, out_q.status};

	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s2 && full_q && !m_tready) |=> v_s2)
		else $error("result register overwritten");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
		else $error("waiting result changed");
	a_single: assert property (@(posedge clk) disable iff (!arst_n)
		!(v_s1 && v_s2)) else $error("two items in flight");
	a_r0: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s2 && res.reg_write) |-> res.reg_index != 5'd0)
		else $error("register zero written");
endmodule

// ===== hdl/miex_regfile.sv =====
// General register file: 32 x 64 memory with registered reads on two ports.
module miex_regfile
	import miex_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        rd_en,
	input  logic [4:0]  rd_a,
	input  logic [4:0]  rd_b,
	output logic [63:0] a_data,
	output logic [63:0] b_data,
	input  logic        wr_en,
	input  logic [4:0]  wr_idx,
	input  logic [63:0] wr_data
);
	logic [63:0] regs [32];
	logic [31:0] vld_q;
	logic [63:0] ra_q, rb_q;
	logic        va_q, vb_q;

	// Valid bits stand for the reset to zero; register zero is never written.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
			va_q  <= 1'b0;
			vb_q  <= 1'b0;
		end else begin
			if (wr_en) vld_q[wr_idx] <= 1'b1;
			if (rd_en) begin
				va_q <= vld_q[rd_a] || (wr_en && wr_idx == rd_a);
				vb_q <= vld_q[rd_b] || (wr_en && wr_idx == rd_b);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) regs[wr_idx] <= wr_data;
		if (rd_en) begin
			ra_q <= (wr_en && wr_idx == rd_a) ? wr_data : regs[rd_a];
			rb_q <= (wr_en && wr_idx == rd_b) ? wr_data : regs[rd_b];
		end
	end

	assign a_data = va_q ? ra_q : '0;
	assign b_data = vb_q ? rb_q : '0;
endmodule

// ===== hdl/miex_dmem.sv =====
// Data memory: 64-bit words, one registered read port and one write port.
module miex_dmem #(
	parameter int AW = 12
) (
	input  logic          clk,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_idx,
	output logic [63:0]   rd_data,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_idx,
	input  logic [63:0]   wr_data
);
	logic [63:0] mem [2**AW];
	logic [63:0] q;

	always_ff @(posedge clk) begin
		if (wr_en) mem[wr_idx] <= wr_data;
		if (rd_en) q <= (wr_en && wr_idx == rd_idx) ? wr_data : mem[rd_idx];
	end

	assign rd_data = q;
endmodule

// ===== hdl/miex_alu.sv =====
// Execute logic: ALU, branches, load extraction and store merge for one instruction.
module miex_alu
	import miex_pkg::*;
(
	input  dec_t        dec,
	input  logic [63:0] a,
	input  logic [63:0] b,
	input  logic [31:0] addr,
	input  logic [63:0] word,
	input  logic [3:0]  sa_in,
	output res_t        res,
	output logic        sa_we,
	output logic [3:0]  sa_new
);
	always_comb begin
		logic [63:0] simm, rval, data, zimm, e;
		logic [2:0]  s8;
		logic [1:0]  s4;
		logic [31:0] m32, boff, pc8;
		logic        cond, isbr, likely, rw, mw;
		logic [7:0]  bm;
		logic [4:0]  ridx;

		simm = {{48{dec.imm[15]}}, dec.imm};
		zimm = {48'd0, dec.imm};
		s8 = addr[2:0];
		s4 = addr[1:0];
		m32 = addr[2] ? word[63:32] : word[31:0];
		boff = dec.pc + 32'd4 + {simm[29:0], 2'b00};
		pc8 = dec.pc + 32'd8;
		rval = '0; data = '0; bm = '0; rw = 1'b0; mw = 1'b0; ridx = dec.rt;
		cond = 1'b0; isbr = 1'b0; likely = 1'b0;
		sa_we = 1'b0; sa_new = sa_in;
		res = '0;
		res.status = dec.status;

		if (dec.status == ST_EXEC) begin
			case (dec.op)
				OP_REGIMM: begin
					if (dec.rt == RI_MTSAB) begin
						sa_we = 1'b1; sa_new = a[3:0] ^ dec.imm[3:0];
					end else if (dec.rt == RI_MTSAH) begin
						sa_we = 1'b1; sa_new = {a[2:0] ^ dec.imm[2:0], 1'b0};
					end else begin
						cond = dec.rt[0] ? !a[63] : a[63];
						likely = dec.rt[1];
						isbr = 1'b1;
						if (dec.rt[4]) begin
							rw = 1'b1; ridx = 5'd31; rval = sx32(pc8);
						end
					end
				end
				OP_J, OP_JAL: begin
					res.branch_taken = 1'b1;
					res.branch_target = {boff[31:28] & 4'hF, dec.jidx, 2'b00};
					res.branch_target[31:28] = dec.pc[31:28] + {3'd0, &dec.pc[27:2]};
					if (dec.op == OP_JAL) begin
						rw = 1'b1; ridx = 5'd31; rval = sx32(pc8);
					end
				end
				6'h04, 6'h05, 6'h06, 6'h07, 6'h14, 6'h15, 6'h16, 6'h17: begin
					case (dec.op[1:0])
						2'd0: cond = a == b;
						2'd1: cond = a != b;
						2'd2: cond = a[63] || a == '0;
						default: cond = !a[63] && a != '0;
					endcase
					likely = dec.op[4];
					isbr = 1'b1;
				end
				OP_ADDI, OP_ADDIU: begin rw = 1'b1; rval = sx32(a[31:0] + simm[31:0]); end
				OP_SLTI: begin
					rw = 1'b1; rval = {63'd0, $signed(a) < $signed(simm)};
				end
				OP_SLTIU: begin rw = 1'b1; rval = {63'd0, a < simm}; end
				OP_ANDI: begin rw = 1'b1; rval = a & zimm; end
				OP_ORI: begin rw = 1'b1; rval = a | zimm; end
				OP_XORI: begin rw = 1'b1; rval = a ^ zimm; end
				OP_LUI: begin rw = 1'b1; rval = sx32({dec.imm, 16'd0}); end
				OP_DADDIU: begin rw = 1'b1; rval = a + simm; end
				OP_LDL: begin
					rw = 1'b1;
					rval = (b & (64'h00ffffffffffffff >> {s8, 3'b000}))
						| (word << {3'd7 - s8, 3'b000});
				end
				OP_LDR: begin
					rw = 1'b1;
					rval = (b & ~(64'hffffffffffffffff >> {s8, 3'b000}))
						| (word >> {s8, 3'b000});
				end
				OP_LB: begin
					rw = 1'b1; e = word >> {s8, 3'b000}; rval = {{56{e[7]}}, e[7:0]};
				end
				OP_LBU: begin rw = 1'b1; e = word >> {s8, 3'b000}; rval = {56'd0, e[7:0]}; end
				OP_LH: begin
					rw = 1'b1; e = word >> {s8[2:1], 4'b0000};
					rval = {{48{e[15]}}, e[15:0]};
				end
				OP_LHU: begin
					rw = 1'b1; e = word >> {s8[2:1], 4'b0000}; rval = {48'd0, e[15:0]};
				end
				OP_LW: begin rw = 1'b1; rval = sx32(m32); end
				OP_LWU: begin rw = 1'b1; rval = {32'd0, m32}; end
				OP_LD: begin rw = 1'b1; rval = word; end
				OP_LWL: begin
					rw = 1'b1;
					rval = sx32((b[31:0] & (32'h00FFFFFF >> {s4, 3'b000}))
						| (m32 << {2'd3 - s4, 3'b000}));
				end
				OP_LWR: begin
					rw = 1'b1;
					rval = sx32((b[31:0] & ~(32'hFFFFFFFF >> {s4, 3'b000}))
						| (m32 >> {s4, 3'b000}));
				end
				OP_SB: begin
					mw = 1'b1; data = {56'd0, b[7:0]} << {s8, 3'b000}; bm = 8'd1 << s8;
				end
				OP_SH: begin
					mw = 1'b1; data = {48'd0, b[15:0]} << {s8[2:1], 4'b0000};
					bm = 8'd3 << {s8[2:1], 1'b0};
				end
				OP_SW: begin
					mw = 1'b1; data = {32'd0, b[31:0]} << {s8[2], 5'b00000};
					bm = 8'hF << {s8[2], 2'b00};
				end
				OP_SD: begin mw = 1'b1; data = b; bm = 8'hFF; end
				OP_SWL: begin
					mw = 1'b1;
					data = {32'd0, b[31:0] >> {2'd3 - s4, 3'b000}} << {s8[2], 5'b00000};
					bm = {4'd0, 4'hF >> (2'd3 - s4)} << {s8[2], 2'b00};
				end
				OP_SWR: begin
					mw = 1'b1;
					data = {32'd0, b[31:0] << {s4, 3'b000}} << {s8[2], 5'b00000};
					bm = {4'd0, 4'hF << s4} << {s8[2], 2'b00};
				end
				OP_SDL: begin
					mw = 1'b1; data = b >> {3'd7 - s8, 3'b000};
					bm = 8'hFF >> (3'd7 - s8);
				end
				OP_SDR: begin
					mw = 1'b1; data = b << {s8, 3'b000}; bm = 8'hFF << s8;
				end
				default: ;
			endcase
		end

		if (isbr) begin
			if (cond) begin
				res.branch_taken = 1'b1; res.branch_target = boff;
			end else if (likely) begin
				res.nullify_next = 1'b1;
			end
		end
		if (rw && ridx != 5'd0) begin
			res.reg_write = 1'b1; res.reg_index = ridx; res.reg_value = rval;
		end
		if (mw) begin
			e = lanes(bm);
			res.mem_write = 1'b1;
			res.mem_word_value = (word & ~e) | (data & e);
			res.mem_byte_mask = bm;
		end
		res.shift_amount_out = sa_new;
	end
endmodule
